// ===== src/sorted_table_binary_search_defines.svh =====
// Assertion macros shared by the sorted table search block.
`ifndef SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define STS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define STS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sts_pkg.sv =====
// Types and constants of the sorted table search block.
`default_nettype none

package sts_pkg;

    localparam int FIELD_VALUE_W = 32;
    localparam int FIELD_INDEX_W = 10;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic                            opcode;
        logic        [FIELD_INDEX_W-1:0] entry_index;
        logic signed [FIELD_VALUE_W-1:0] entry_value;
        logic signed [FIELD_VALUE_W-1:0] search_key;
        logic        [FIELD_INDEX_W-1:0] low_bound;
        logic        [FIELD_INDEX_W-1:0] high_bound;
    } t_in_word;

    typedef struct packed {
        logic                     found;
        logic [FIELD_INDEX_W-1:0] match_index;
    } t_out_word;

    typedef enum logic {
        ST_IDLE,
        ST_PROBE
    } t_state;

endpackage

`default_nettype wire

// ===== src/sts_table_ram.sv =====
// Table memory: one write port, one read port with registered data.
`default_nettype none

module sts_table_ram #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32,
    parameter int AW          = 10
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_wr_en,
    input  wire logic [AW-1:0]          i_wr_addr,
    input  wire logic [VALUE_WIDTH-1:0] i_wr_data,
    input  wire logic                   i_rd_en,
    input  wire logic [AW-1:0]          i_rd_addr,
    output logic      [VALUE_WIDTH-1:0] o_rd_data
);

    logic [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/sts_search_ctrl.sv =====
// Search sequencer: writes entries, walks the range one probe per cycle.
`default_nettype none

module sts_search_ctrl
    import sts_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32,
    parameter int AW          = 10
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    input  wire t_in_word               i_word,
    output logic                        busy,
    output logic                        o_done,
    output t_out_word                   o_word,
    output logic                        o_wr_en,
    output logic      [AW-1:0]          o_wr_addr,
    output logic      [VALUE_WIDTH-1:0] o_wr_data,
    output logic                        o_rd_en,
    output logic      [AW-1:0]          o_rd_addr,
    input  wire logic [VALUE_WIDTH-1:0] i_rd_data
);

    t_state                   r_state, n_state;
    logic [FIELD_INDEX_W-1:0] r_lo, n_lo;
    logic [FIELD_INDEX_W-1:0] r_hi, n_hi;
    logic [FIELD_INDEX_W-1:0] r_mid, n_mid;
    logic [VALUE_WIDTH-1:0]   r_key, n_key;
    logic                     r_done, n_done;
    t_out_word                r_out, n_out;

    logic                     accept;
    logic [63:0]              key_ext;
    logic [63:0]              val_ext;
    logic [FIELD_INDEX_W-1:0] hi_sat;
    logic [FIELD_INDEX_W:0]   mid_sum;
    logic                     probe_lt;
    logic                     probe_eq;

    assign accept  = start && (r_state == ST_IDLE);
    assign key_ext = {{(64 - FIELD_VALUE_W){i_word.search_key[FIELD_VALUE_W-1]}},
                      i_word.search_key};
    assign val_ext = {{(64 - FIELD_VALUE_W){i_word.entry_value[FIELD_VALUE_W-1]}},
                      i_word.entry_value};
    assign probe_eq = (i_rd_data == r_key);
    assign probe_lt = ($signed(i_rd_data) < $signed(r_key));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        r_key <= n_key;
        r_out <= n_out;
    end

    always_comb begin
        n_state   = r_state;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        n_key     = r_key;
        n_done    = 1'b0;
        n_out     = r_out;
        o_wr_en   = 1'b0;
        o_wr_addr = AW'(i_word.entry_index);
        o_wr_data = val_ext[VALUE_WIDTH-1:0];
        o_rd_en   = 1'b0;
        hi_sat    = i_word.high_bound;
        mid_sum   = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (32'(i_word.high_bound) > TABLE_DEPTH - 1) begin
                    hi_sat = FIELD_INDEX_W'(TABLE_DEPTH - 1);
                end
                mid_sum = {1'b0, i_word.low_bound} + {1'b0, hi_sat};
                if (accept && i_word.opcode == OP_WRITE) begin
                    o_wr_en = (32'(i_word.entry_index) < TABLE_DEPTH);
                end else if (accept) begin
                    if (hi_sat < i_word.low_bound) begin
                        n_done = 1'b1;
                        n_out  = '{found: 1'b0, match_index: '0};
                    end else begin
                        n_lo    = i_word.low_bound;
                        n_hi    = hi_sat;
                        n_mid   = mid_sum[FIELD_INDEX_W:1];
                        n_key   = key_ext[VALUE_WIDTH-1:0];
                        o_rd_en = 1'b1;
                        n_state = ST_PROBE;
                    end
                end
            end
            ST_PROBE: begin
                // read data belongs to r_mid
                priority if (probe_eq) begin
                    n_done  = 1'b1;
                    n_out   = '{found: 1'b1, match_index: r_mid};
                    n_state = ST_IDLE;
                end else if (probe_lt) begin
                    if (r_mid == r_hi) begin
                        n_done  = 1'b1;
                        n_out   = '{found: 1'b0, match_index: '0};
                        n_state = ST_IDLE;
                    end else begin
                        n_lo    = r_mid + 1'b1;
                        mid_sum = {1'b0, n_lo} + {1'b0, r_hi};
                        n_mid   = mid_sum[FIELD_INDEX_W:1];
                        o_rd_en = 1'b1;
                    end
                end else begin
                    if (r_mid == r_lo) begin
                        n_done  = 1'b1;
                        n_out   = '{found: 1'b0, match_index: '0};
                        n_state = ST_IDLE;
                    end else begin
                        n_hi    = r_mid - 1'b1;
                        mid_sum = {1'b0, r_lo} + {1'b0, n_hi};
                        n_mid   = mid_sum[FIELD_INDEX_W:1];
                        o_rd_en = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_rd_addr = AW'(n_mid);
    assign busy      = (r_state != ST_IDLE);
    assign o_done    = r_done;
    assign o_word    = r_out;

endmodule

`default_nettype wire

// ===== src/sorted_table_binary_search.sv =====
// Top level of the sorted table search block: table memory plus sequencer.
//
//  channel | direction | handshake        | word
//  --------+-----------+------------------+-------------------------------------
//  command | in        | start & !busy    | i_word  (opcode, entry, key, bounds)
//  result  | out       | o_done, 1 cycle  | o_word  (found, match_index)
//
// A write word is taken without raising busy and gives no result; the next
// word may follow at once. A search issues one table read per probe; the read
// data of one probe picks the next midpoint in the same cycle, so a search
// holds busy while it probes and shows o_done in the cycle after its last
// probe (at most 11 probes for a 1024-entry range). An empty range answers
// in the cycle after start. The read latency of the table memory sets the
// probe rate. Reset is synchronous and clears only control state; the
// table holds no reset value. The receiver cannot stall: o_done lasts one
// cycle and a new word may be taken in that same cycle.
`default_nettype none

`include "sorted_table_binary_search_defines.svh"

module sorted_table_binary_search
    import sts_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    input  wire t_in_word i_word,
    output logic          busy,
    output logic          o_done,
    output t_out_word     o_word
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [VALUE_WIDTH-1:0] rd_data;

    // table storage
    sts_table_ram #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .AW          (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // command decode and probe sequencing
    sts_search_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .AW          (AW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_word    (i_word),
        .busy      (busy),
        .o_done    (o_done),
        .o_word    (o_word),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data)
    );

    // a miss reports index zero
    `STS_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, o_done && !o_word.found, o_word.match_index == '0, "miss with nonzero index")
    // a write word never produces a result
    `STS_ASSERT_NEXT(a_write_silent, i_clk, i_rst_n, start && !busy && i_word.opcode == OP_WRITE, !o_done, "result after write")
    // a search either probes or answers right away
    `STS_ASSERT_NEXT(a_search_moves, i_clk, i_rst_n, start && !busy && i_word.opcode == OP_SEARCH, busy || o_done, "search dropped")
    // the table is never written during a search
    `STS_ASSERT_NOW(a_no_write_busy, i_clk, i_rst_n, busy, !wr_en, "table write while searching")

endmodule

`default_nettype wire

// ===== sim/tb_sorted_table_binary_search.sv =====
// Self-checking testbench for the sorted table search block: table loads and key lookups.
module tb_sorted_table_binary_search;
    import sts_pkg::*;

    localparam int DEPTH        = 1024;
    localparam int ITEM_COUNT   = 1350;  // words sent before the stimulus stops
    localparam int CALM_TAIL    = 150;   // last words go out back to back
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 16;    // one full search plus margin

    typedef logic signed [FIELD_VALUE_W-1:0] t_value;
    typedef int t_probe_list [$];

    localparam t_value VAL_MIN = {1'b1, {(FIELD_VALUE_W-1){1'b0}}};
    localparam t_value VAL_MAX = {1'b0, {(FIELD_VALUE_W-1){1'b1}}};

    // Holds a copy of the table as the block should see it, and the lookups
    // still owed by the block, oldest first.
    class search_scoreboard;
        t_value    entries [DEPTH];
        t_out_word awaited [$];
        int        errors;

        // Halving search over a table image. Also hands back every probed
        // index so the stimulus can load exactly those entries first.
        static function t_out_word bisect(input t_value vals [DEPTH], input t_value key,
                                          input int lo, input int hi,
                                          output t_probe_list path);
            t_out_word res;
            int        mid;
            res  = '0;
            path = {};
            if (hi > DEPTH - 1) hi = DEPTH - 1;
            while (lo <= hi) begin
                mid = (lo + hi) / 2;
                path.push_back(mid);
                if (vals[mid] > key) begin
                    hi = mid - 1;
                end else if (vals[mid] < key) begin
                    lo = mid + 1;
                end else begin
                    res.found       = 1'b1;
                    res.match_index = mid[FIELD_INDEX_W-1:0];
                    break;
                end
            end
            return res;
        endfunction

        function void note_word(input t_in_word w);
            t_probe_list path;
            if (w.opcode == OP_WRITE) begin
                entries[w.entry_index] = w.entry_value;
            end else begin
                awaited.push_back(bisect(entries, w.search_key, int'(w.low_bound),
                                         int'(w.high_bound), path));
            end
        endfunction

        function void check_word(input t_out_word got);
            t_out_word want;
            if (awaited.size() == 0) begin
                $error("result word with no search outstanding: found %0d, match_index %0d",
                       got.found, got.match_index);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.found !== want.found) begin
                $error("found: expected %0d, actual %0d", want.found, got.found);
                errors++;
            end
            if (got.match_index !== want.match_index) begin
                $error("match_index: expected %0d, actual %0d",
                       want.match_index, got.match_index);
                errors++;
            end
        endfunction
    endclass

    // Clock and the block's inputs, all known from time zero.
    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_word  word    = '0;
    logic      busy;
    logic      o_done;
    t_out_word o_word;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sorted_table_binary_search DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_word  (word),
        .busy    (busy),
        .o_done  (o_done),
        .o_word  (o_word)
    );

    search_scoreboard sb = new;

    // Stimulus-side view of the table. plan holds the value every entry is
    // meant to have in the current load; fresh marks entries whose value in
    // the block already equals plan. A lookup first loads every stale entry on
    // its probe path, so no probe ever lands on an entry never written.
    t_value plan  [DEPTH];
    bit     fresh [DEPTH];
    int     sent;
    int     idle_pct = 20;
    int     cycles;

    // Both monitors sample on the edge, before the drivers' updates land.
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) sb.note_word(word);
        if (i_rst_n && o_done) sb.check_word(o_word);
    end

    // Watchdog: covers a hung handshake and a missing result alike.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Random word; fields that the opcode leaves unused keep their noise.
    function automatic t_in_word noise_word();
        t_in_word   w;
        bit [31:0]  r;
        r             = $urandom;
        w.opcode      = r[0];
        w.entry_index = r[FIELD_INDEX_W:1];
        w.low_bound   = r[2*FIELD_INDEX_W:FIELD_INDEX_W+1];
        r             = $urandom;
        w.high_bound  = r[FIELD_INDEX_W-1:0];
        w.entry_value = $urandom;
        w.search_key  = $urandom;
        return w;
    endfunction

    task automatic pause(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Present one word and hold it until the block takes it. start stays high
    // afterward so the next word can follow without a gap.
    task automatic issue(input t_in_word w);
        if (sent < ITEM_COUNT - CALM_TAIL && $urandom_range(99) < idle_pct)
            pause($urandom_range(1, 14));
        start <= 1'b1;
        word  <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent++;
    endtask

    task automatic put(input int idx, input t_value v);
        t_in_word w;
        w             = noise_word();
        w.opcode      = OP_WRITE;
        w.entry_index = idx[FIELD_INDEX_W-1:0];
        w.entry_value = v;
        plan[idx]     = v;
        fresh[idx]    = 1'b1;
        issue(w);
    endtask

    task automatic seek(input t_value key, input int lo, input int hi);
        t_probe_list path;
        t_out_word   unused_res;
        t_in_word    w;
        // Loading path entries with their planned values leaves the path as is.
        unused_res = search_scoreboard::bisect(plan, key, lo, hi, path);
        foreach (path[j]) begin
            if (!fresh[path[j]]) put(path[j], plan[path[j]]);
        end
        w            = noise_word();
        w.opcode     = OP_SEARCH;
        w.search_key = key;
        w.low_bound  = lo[FIELD_INDEX_W-1:0];
        w.high_bound = hi[FIELD_INDEX_W-1:0];
        issue(w);
    endtask

    // New ascending load. Small steps give runs of duplicates, large steps
    // spread the values over the whole signed span.
    function automatic void new_load();
        int     smax;
        longint span;
        longint acc;
        case ($urandom_range(3))
            0: begin
                smax = 1;
            end
            1: begin
                smax = 4;
            end
            2: begin
                smax = 5000;
            end
            default: begin
                smax = 2097152;
            end
        endcase
        span = 64'd4294967295 - 1023 * longint'(smax);
        acc  = $urandom;
        acc  = longint'(VAL_MIN) + acc % (span + 1);
        if ($urandom_range(5) == 0) acc = longint'(VAL_MIN);
        for (int i = 0; i < DEPTH; i++) begin
            plan[i]  = acc[FIELD_VALUE_W-1:0];
            fresh[i] = 1'b0;
            acc     += $urandom_range(0, smax);
        end
        if ($urandom_range(5) == 0) plan[DEPTH-1] = VAL_MAX;
    endfunction

    initial begin
        longint   acc;
        int       lo;
        int       hi;
        int       width;
        int       pick;
        t_value   key;
        bit [31:0] r;

        // Even ramp from the most negative value up to the largest one.
        for (int i = 0; i < DEPTH; i++) begin
            acc     = longint'(VAL_MIN) + longint'(i) * 4194304;
            plan[i] = (i == DEPTH - 1) ? VAL_MAX : acc[FIELD_VALUE_W-1:0];
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed words ----
        put(0, VAL_MIN);
        seek(VAL_MIN, 0, 0);                   // smallest value, found at index 0
        r = $urandom;
        seek(r, 7, 2);                         // high bound below low bound
        put(DEPTH - 1, VAL_MAX);
        seek(VAL_MAX, DEPTH - 1, DEPTH - 1);   // largest value at the last index
        seek(VAL_MIN, DEPTH - 1, DEPTH - 1);   // key below the last entry, miss at the last index
        put(0, t_value'(-5));
        seek(VAL_MIN, 0, 0);                   // range steps below index 0
        seek(t_value'(-5), 0, 0);
        put(0, VAL_MIN);
        seek(VAL_MAX, 0, DEPTH - 1);           // full range, longest probe path

        // ---- random words ----
        while (sent < ITEM_COUNT) begin
            if ($urandom_range(59) == 0) begin
                new_load();
                case ($urandom_range(2))
                    0: begin
                        idle_pct = 0;
                    end
                    1: begin
                        idle_pct = 10;
                    end
                    default: begin
                        idle_pct = 35;
                    end
                endcase
            end
            pick = $urandom_range(99);
            if (pick < 5) begin
                // stray write; leaves the table unsorted until the next load
                r = $urandom;
                put($urandom_range(0, DEPTH - 1), r);
            end else if (pick < 10) begin
                lo = $urandom_range(1, DEPTH - 1);
                hi = $urandom_range(0, lo - 1);
                r  = $urandom;
                seek(r, lo, hi);
            end else begin
                pick = $urandom_range(99);
                if (pick < 75) width = $urandom_range(0, 31);
                else if (pick < 95) width = $urandom_range(32, 300);
                else width = DEPTH - 1 - $urandom_range(0, 6);
                lo = $urandom_range(0, DEPTH - 1 - width);
                hi = lo + width;
                pick = $urandom_range(99);
                if (pick < 50) begin
                    key = plan[$urandom_range(lo, hi)];
                end else if (pick < 70) begin
                    // neighbors of a stored value, usually a miss
                    key = plan[$urandom_range(lo, hi)] + ($urandom_range(1) ? 1 : -1);
                end else if (pick < 85) begin
                    key = $urandom;
                end else if (pick < 90) begin
                    key = $urandom_range(1) ? VAL_MAX : VAL_MIN;
                end else begin
                    key = plan[$urandom_range(0, DEPTH - 1)];
                end
                seek(key, lo, hi);
            end
        end
        start <= 1'b0;

        // Drain: every search owes exactly one result.
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
